// ----- src/dbd_pkg.sv -----
// ----------------------------------------------------------------------------
// dbd_pkg: shared types and constants for the days-between-dates block
// Field widths, decimal split phase codes, controller command struct and
// calendar lookup functions used by both the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

  // Field and internal widths
  localparam int FIELD_W  = 27;  // packed yyyymmdd date
  localparam int COUNT_W  = 22;  // day count result
  localparam int IN_W     = 56;  // two dates, padded to whole bytes
  localparam int OUT_W    = 24;  // day count, padded to whole bytes
  localparam int CENT_W   = 8;   // date / 1000000, at most 134
  localparam int DIG_W    = 7;   // two decimal digits, at most 99
  localparam int YEAR_W   = 14;  // year plus offset, at most 13899
  localparam int Y100_W   = 9;   // shifted year / 100
  localparam int SERIAL_W = 23;  // serial day number
  localparam int CNT_W    = 1;   // split step counter
  localparam int DOY_W    = 9;   // days since 1 March
  localparam int QUO_W    = 21;  // date / 100, at most 1342177

  // Divide by 100 as multiply by ceil(2^33 / 100) and shift; exact for any
  // 27-bit dividend since 8 * 2^27 < 2^33
  localparam logic [FIELD_W-1:0] RECIP_100 = FIELD_W'(85899346);
  localparam int                 RECIP_SH  = 33;

  // Cycles of each split phase, less one: multiply, then remainder
  localparam logic [CNT_W-1:0]   SPLIT_CNT = CNT_W'(1);

  // Decimal split phases: day, then month, then year digits and century
  typedef enum logic [1:0] {
    PH_DAY,
    PH_MON,
    PH_YEAR
  } phase_t;

  // Controller to datapath commands
  typedef struct packed {
    logic   capture;  // latch both dates from the input transaction
    logic   load;     // load the remainder with the selected date
    logic   sel_b;    // working on the second date
    logic   step;     // one split step
    logic   last;     // final step of the current phase
    phase_t phase;
    logic   do_year;
    logic   do_prod;
    logic   do_sum;
    logic   do_out;
  } dbd_cmd_t;

  function automatic phase_t next_phase(phase_t ph);
    phase_t r;
    case (ph)
      PH_DAY:  r = PH_MON;
      PH_MON:  r = PH_YEAR;
      default: r = PH_DAY;
    endcase
    return r;
  endfunction

  // Month length, with February set by the leap flag
  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] r;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Days from 1 March to the first of the month (year starts in March)
  function automatic logic [DOY_W-1:0] cum_days(logic [3:0] mon);
    logic [DOY_W-1:0] r;
    case (mon)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/days_between_dates.sv -----
// After the accepting edge, each date in turn goes through load, decimal split
//   (multiply and remainder for each digit pair), year assembly, product and sum;
//   then the difference state registers the result, waiting while an earlier
//   result still waits for m_tready. s_tready is high only in the idle state.
// A finished result waits in the output register while the next date pair is
//   accepted and worked on. Reset (rst, synchronous): idle, output valid clears.
// ----------------------------------------------------------------------------
// days_between_dates: Gregorian day count between two packed dates
// Splits two decimal yyyymmdd dates, checks them and returns the absolute
// number of days between them, or an invalid flag with a zero count.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // [26:0] first_date, [53:27] second_date, [55:54] zero
  input  wire logic [dbd_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // [21:0] day_count, [23:22] zero
  output logic [dbd_pkg::OUT_W-1:0]      m_tdata,
  // [0] invalid
  output logic                           m_tuser
);

  dbd_pkg::dbd_cmd_t              cmd;
  logic [dbd_pkg::COUNT_W-1:0]    day_count;
  logic                           invalid;

  dbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  dbd_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk         (clk),
    .first_date  (s_tdata[dbd_pkg::FIELD_W-1:0]),
    .second_date (s_tdata[2*dbd_pkg::FIELD_W-1:dbd_pkg::FIELD_W]),
    .cmd         (cmd),
    .day_count   (day_count),
    .invalid     (invalid)
  );

  assign m_tdata = {{(dbd_pkg::OUT_W - dbd_pkg::COUNT_W){1'b0}}, day_count};
  assign m_tuser = invalid;

endmodule

`default_nettype wire

// ----- src/dbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dbd_ctrl: sequencing controller
// Accepts a transaction, walks the datapath through the decimal split and
// serial-day evaluation of each date, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output dbd_pkg::dbd_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_YEAR,
    S_PROD,
    S_SUM,
    S_DIFF
  } state_t;

  state_t                     state;
  dbd_pkg::phase_t            phase;
  logic [dbd_pkg::CNT_W-1:0]  cnt;
  logic                       sel_b;
  logic                       out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.capture = s_tvalid && (state == S_IDLE);
    cmd.load    = (state == S_LOAD);
    cmd.sel_b   = sel_b;
    cmd.step    = (state == S_DIV);
    cmd.last    = (state == S_DIV) && (cnt == '0);
    cmd.phase   = phase;
    cmd.do_year = (state == S_YEAR);
    cmd.do_prod = (state == S_PROD);
    cmd.do_sum  = (state == S_SUM);
    cmd.do_out  = (state == S_DIFF) && (!out_valid || m_tready);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= dbd_pkg::PH_DAY;
      cnt       <= '0;
      sel_b     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          sel_b <= 1'b0;
          if (s_tvalid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          phase <= dbd_pkg::PH_DAY;
          cnt   <= dbd_pkg::SPLIT_CNT;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            if (phase == dbd_pkg::PH_YEAR) begin
              state <= S_YEAR;
            end else begin
              phase <= dbd_pkg::next_phase(phase);
              cnt   <= dbd_pkg::SPLIT_CNT;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_YEAR: state <= S_PROD;
        S_PROD: state <= S_SUM;
        S_SUM: begin
          if (sel_b) begin
            state <= S_DIFF;
          end else begin
            sel_b <= 1'b1;
            state <= S_LOAD;
          end
        end
        S_DIFF: begin
          if (cmd.do_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_accept_loads_first: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOAD && !sel_b))
    else $error("accepted transaction did not start on the first date");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.do_out |-> (!out_valid || m_tready))
    else $error("pending result overwritten");

  a_split_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == '0 && phase == dbd_pkg::PH_YEAR) |=> (state == S_YEAR))
    else $error("decimal split not followed by year assembly");

  a_second_date_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && sel_b) |=> (state == S_DIFF))
    else $error("second date not followed by difference");

endmodule

`default_nettype wire

// ----- src/dbd_dpath.sv -----
// ----------------------------------------------------------------------------
// dbd_dpath: date split and serial-day datapath
// Shared reciprocal divide-by-100 for the decimal split, calendar check,
// serial-day evaluation of each date and the output register of the count.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_dpath #(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic                        clk,
  input  wire logic [dbd_pkg::FIELD_W-1:0] first_date,
  input  wire logic [dbd_pkg::FIELD_W-1:0] second_date,
  input  wire dbd_pkg::dbd_cmd_t           cmd,
  output logic [dbd_pkg::COUNT_W-1:0]      day_count,
  output logic                             invalid
);

  localparam int FW = dbd_pkg::FIELD_W;
  localparam int YW = dbd_pkg::YEAR_W;
  localparam int SW = dbd_pkg::SERIAL_W;
  localparam int DW = dbd_pkg::DIG_W;

  logic [FW-1:0]               date_a, date_b;
  logic [FW-1:0]               rem;
  logic [dbd_pkg::QUO_W-1:0]   quo;
  logic [dbd_pkg::CENT_W-1:0]  cent;
  logic [DW-1:0]               yy, month, day;
  logic [YW-1:0]               year, yprime;
  logic [dbd_pkg::Y100_W-1:0]  y100;
  logic                        leap;
  logic [SW-1:0]               prod;
  logic                        valid_cur;
  logic [SW-1:0]               sa, sb;
  logic                        ok_a, ok_b;

  // Split step: quotient by reciprocal multiply, then the two-digit remainder
  logic [2*FW-1:0]             recip_prod;
  logic [FW-1:0]               rem_lo;

  assign recip_prod = {{FW{1'b0}}, rem} * {{FW{1'b0}}, dbd_pkg::RECIP_100};
  assign rem_lo     = rem - FW'(quo) * FW'(100);

  // Year assembly terms
  logic          adj;
  logic [YW-1:0] year_c;

  assign adj    = (month <= DW'(2));
  assign year_c = YW'(cent) * YW'(100) + YW'(yy);

  // Serial day sum
  logic [SW-1:0] serial;

  assign serial = prod + SW'(yprime >> 2) - SW'(y100) + SW'(y100 >> 2)
                + SW'(dbd_pkg::cum_days(month[3:0])) + SW'(day) - SW'(1);

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      date_a <= first_date;
      date_b <= second_date;
    end
  end

  // Decimal split, quotient then remainder for each digit pair
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= cmd.sel_b ? date_b : date_a;
    end else if (cmd.step) begin
      if (cmd.last) begin
        case (cmd.phase)
          dbd_pkg::PH_DAY: day   <= rem_lo[DW-1:0];
          dbd_pkg::PH_MON: month <= rem_lo[DW-1:0];
          dbd_pkg::PH_YEAR: begin
            yy   <= rem_lo[DW-1:0];
            cent <= quo[dbd_pkg::CENT_W-1:0];
          end
          default: ;
        endcase
        rem <= FW'(quo);
      end else begin
        quo <= recip_prod[dbd_pkg::RECIP_SH +: dbd_pkg::QUO_W];
      end
    end
  end

  // Serial day evaluation
  always_ff @(posedge clk) begin
    if (cmd.do_year) begin
      year   <= year_c;
      // March-based year, offset by 400 to keep terms positive
      yprime <= year_c + YW'(400) - YW'(adj);
      y100   <= (yy >= DW'(adj)) ? (dbd_pkg::Y100_W'(cent) + 9'd4)
                                 : (dbd_pkg::Y100_W'(cent) + 9'd3);
      // 100 divides by 4, so the low two digits settle year mod 4
      leap   <= (yy[1:0] == 2'b00) && ((yy != '0) || (cent[1:0] == 2'b00));
    end
    if (cmd.do_prod) begin
      prod      <= SW'(yprime) * SW'(365);
      valid_cur <= (year <= YW'(MAX_YEAR))
                && (month >= DW'(1)) && (month <= DW'(12))
                && (day >= DW'(1))
                && (day <= DW'(dbd_pkg::month_len(month[3:0], leap)));
    end
    if (cmd.do_sum) begin
      if (cmd.sel_b) begin
        sb   <= serial;
        ok_b <= valid_cur;
      end else begin
        sa   <= serial;
        ok_a <= valid_cur;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.do_out) begin
      if (ok_a && ok_b) begin
        day_count <= (sa >= sb) ? dbd_pkg::COUNT_W'(sa - sb)
                                : dbd_pkg::COUNT_W'(sb - sa);
        invalid   <= 1'b0;
      end else begin
        day_count <= '0;
        invalid   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/days_between_dates_check.sv -----
// ----------------------------------------------------------------------------
// days_between_dates_check: day count predictor and result checker
// Watches both stream channels of the block. Each date pair accepted on the
// input side is turned into an expected day count and invalid flag, which are
// queued. Each result transaction is compared with the oldest queued entry.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates_check
  import dbd_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  // [26:0] first_date, [53:27] second_date, [55:54] zero
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  // [21:0] day_count, [23:22] zero
  input  wire logic [OUT_W-1:0] m_tdata,
  // [0] invalid
  input  wire logic             m_tuser,
  output int                    mismatches,
  output int                    awaited
);

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               invalid;
  } span_t;

  // expected spans, oldest first
  span_t spans_due[$];

  function automatic logic leap_year(int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Split yyyymmdd into its parts; 1 when the date is well formed
  function automatic logic split_ymd(input logic [FIELD_W-1:0] ymd,
                                     output int unsigned yr,
                                     output int unsigned mo,
                                     output int unsigned dy);
    int unsigned v;
    int unsigned last_day;
    v  = ymd;
    yr = v / 10000;
    mo = (v / 100) % 100;
    dy = v % 100;
    case (mo)
      1, 3, 5, 7, 8, 10, 12: last_day = 31;
      4, 6, 9, 11:           last_day = 30;
      2:                     last_day = leap_year(yr) ? 29 : 28;
      default:               last_day = 0;
    endcase
    return (yr <= MAX_YEAR) && (dy >= 1) && (dy <= last_day);
  endfunction

  // Day number with the year starting in March, years offset by 400 so that
  // nothing goes negative; only differences matter
  function automatic int unsigned day_number(int unsigned yr, int unsigned mo,
                                             int unsigned dy);
    int unsigned y;
    int unsigned m_shift;
    y = yr + 400;
    if (mo <= 2) y = y - 1;
    m_shift = (mo + 9) % 12;
    return y * 365 + y / 4 - y / 100 + y / 400 + (153 * m_shift + 2) / 5 + dy - 1;
  endfunction

  function automatic span_t predict_span(logic [IN_W-1:0] dates);
    span_t       r;
    int unsigned ya, ma, da, yb, mb, db;
    int unsigned na, nb;
    logic        ok_a, ok_b;
    ok_a = split_ymd(dates[FIELD_W-1:0], ya, ma, da);
    ok_b = split_ymd(dates[2*FIELD_W-1:FIELD_W], yb, mb, db);
    if (!(ok_a && ok_b)) begin
      r.day_count = '0;
      r.invalid   = 1'b1;
    end else begin
      na          = day_number(ya, ma, da);
      nb          = day_number(yb, mb, db);
      r.day_count = COUNT_W'((na >= nb) ? (na - nb) : (nb - na));
      r.invalid   = 1'b0;
    end
    return r;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    span_t want;
    int    bad;
    bad = 0;
    if (!rst) begin
      if (s_tvalid && s_tready) spans_due.push_back(predict_span(s_tdata));
      if (m_tvalid && m_tready) begin
        if (spans_due.size() == 0) begin
          $display("%0t: unexpected result, day_count %0d invalid %0b", $time,
                   m_tdata[COUNT_W-1:0], m_tuser);
          bad = bad + 1;
        end else begin
          want = spans_due.pop_front();
          if (m_tdata[COUNT_W-1:0] !== want.day_count) begin
            $display("%0t: day_count expected %0d actual %0d", $time,
                     want.day_count, m_tdata[COUNT_W-1:0]);
            bad = bad + 1;
          end
          if (m_tuser !== want.invalid) begin
            $display("%0t: invalid expected %0b actual %0b", $time,
                     want.invalid, m_tuser);
            bad = bad + 1;
          end
        end
      end
    end
    mismatches <= mismatches + bad;
    awaited    <= spans_due.size();
  end

endmodule

`default_nettype wire

// ----- test/days_between_dates_test.sv -----
// ----------------------------------------------------------------------------
// days_between_dates_test: stimulus and verdict for days_between_dates
// Sends a directed set of date pairs (calendar limits, leap rules, bad months,
// bad days, oversized years, equal and swapped dates), then random pairs that
// are mostly real calendar dates with some malformed ones. Both stream sides
// idle at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates_test;
  import dbd_pkg::*;

  localparam int MAX_YEAR     = 9999;
  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_LIMIT  = 3000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 60;    // well over the block's latency

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic [IN_W-1:0]    s_tdata  = '0;
  logic               m_tready = 1'b0;
  logic               steady   = 1'b0;  // no idling on either side
  logic               s_tready;
  logic               m_tvalid;
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tuser;
  int                 mismatches;
  int                 awaited;
  int                 quiet_cycles = 0;
  int                 rx_hold      = 0;

  days_between_dates #(.MAX_YEAR(MAX_YEAR)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  days_between_dates_check #(.MAX_YEAR(MAX_YEAR)) u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: rare long stalls and occasional single-cycle ones
  always @(posedge clk) begin
    int roll;
    roll = $urandom_range(0, 999);
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (steady || roll >= 22) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      if (roll < 2) rx_hold <= $urandom_range(20, 90);
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [FIELD_W-1:0] ymd_of(int unsigned yr, int unsigned mo,
                                                int unsigned dy);
    return FIELD_W'(yr * 10000 + mo * 100 + dy);
  endfunction

  // Mostly real dates; days past the 28th may overrun the month
  function automatic logic [FIELD_W-1:0] calendar_date(int unsigned yr);
    int unsigned mo;
    int unsigned dy;
    mo = $urandom_range(1, 12);
    dy = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
    return ymd_of(yr, mo, dy);
  endfunction

  function automatic logic [FIELD_W-1:0] broken_date();
    logic [FIELD_W-1:0] r;
    case ($urandom_range(0, 4))
      0:       r = ymd_of($urandom_range(0, MAX_YEAR),
                          $urandom_range(0, 1) ? 0 : $urandom_range(13, 99),
                          $urandom_range(1, 31));
      1:       r = ymd_of($urandom_range(0, MAX_YEAR), $urandom_range(1, 12),
                          $urandom_range(0, 1) ? 0 : $urandom_range(32, 99));
      2:       r = ymd_of($urandom_range(MAX_YEAR + 1, 13421),
                          $urandom_range(1, 12), $urandom_range(1, 28));
      default: r = FIELD_W'($urandom);  // any bit pattern
    endcase
    return r;
  endfunction

  // Offer one date pair and wait for its input transaction
  task automatic offer_dates(input logic [FIELD_W-1:0] first_ymd,
                             input logic [FIELD_W-1:0] second_ymd);
    if (!steady && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({second_ymd, first_ymd});
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    int unsigned        yr;
    int                 near;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: calendar limits, leap rules and malformed dates
    offer_dates(ymd_of(0, 1, 1), ymd_of(9999, 12, 31));
    offer_dates(ymd_of(9999, 12, 31), ymd_of(0, 1, 1));
    offer_dates(ymd_of(0, 1, 1), ymd_of(0, 1, 1));
    offer_dates(ymd_of(2023, 6, 15), ymd_of(2023, 6, 15));
    offer_dates(ymd_of(2000, 2, 29), ymd_of(2000, 3, 1));
    offer_dates(ymd_of(1900, 2, 28), ymd_of(1900, 3, 1));
    offer_dates(ymd_of(1900, 2, 29), ymd_of(1900, 3, 1));
    offer_dates(ymd_of(2024, 2, 29), ymd_of(2023, 2, 28));
    offer_dates(ymd_of(2023, 2, 29), ymd_of(2023, 3, 1));
    offer_dates(ymd_of(0, 2, 29), ymd_of(1, 3, 1));
    offer_dates(ymd_of(2023, 0, 15), ymd_of(2023, 1, 15));
    offer_dates(ymd_of(2023, 1, 15), ymd_of(2023, 13, 1));
    offer_dates(ymd_of(2023, 1, 0), ymd_of(2023, 1, 1));
    offer_dates(ymd_of(2023, 1, 31), ymd_of(2023, 1, 32));
    offer_dates(ymd_of(2023, 4, 31), ymd_of(2023, 4, 30));
    offer_dates(ymd_of(2023, 4, 30), ymd_of(2023, 12, 31));
    offer_dates(ymd_of(10000, 1, 1), ymd_of(9999, 1, 1));
    offer_dates(ymd_of(2020, 5, 5), '1);
    offer_dates('0, ymd_of(2020, 5, 5));
    offer_dates(ymd_of(1970, 1, 1), ymd_of(2023, 12, 31));
    offer_dates(ymd_of(2023, 12, 31), ymd_of(1970, 1, 1));
    offer_dates(ymd_of(1999, 12, 31), ymd_of(2000, 1, 1));

    // Random: mostly real dates, some near each other, some malformed
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= (i >= 300 && i < 420);
      yr = $urandom_range(0, MAX_YEAR);
      a  = calendar_date(yr);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b = calendar_date($urandom_range(0, MAX_YEAR));
        4, 5, 6, 7: begin
          near = int'(yr) + int'($urandom_range(0, 2)) - 1;
          if (near < 0 || near > MAX_YEAR) near = int'(yr);
          b = calendar_date(near);
        end
        8:       b = broken_date();
        default: begin
          b = a;
          a = broken_date();
        end
      endcase
      offer_dates(a, b);
    end
    s_tvalid <= 1'b0;
    steady   <= 1'b0;

    // Drain, then watch for stray results
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
